FILE: rtl/core/pdc_pkg.sv
`default_nettype none
package pdc_pkg;

	typedef struct packed {
		logic signed [15:0] error_in;
		logic        [15:0] time_step;
	} in_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               in_deadband;
		logic               limited;
	} out_t;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t REG_KP       = 3'd0;
	localparam cfg_index_t REG_KI       = 3'd1;
	localparam cfg_index_t REG_KD       = 3'd2;
	localparam cfg_index_t REG_OUT_LIM  = 3'd3;
	localparam cfg_index_t REG_DEADBAND = 3'd4;

	// derivative divider: |kd*diff| * 2^16 over a 16-bit time step
	localparam int DIV_WIDTH     = 48;
	localparam int DIV_BITS      = 3;
	localparam int DIV_STEPS     = DIV_WIDTH / DIV_BITS;
	localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic acc;
		logic sum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/pid_deadband_clamp.sv
`default_nettype none
// PID controller with deadband and symmetric output clamp. One item in, one
// result out; items are worked one at a time, and a new item is taken only once
// the previous one has gone through two multiply stages, the integral update,
// the derivative divider (3 quotient bits per cycle over a 48-bit dividend),
// a sum stage and the clamp stage that loads the output
// register. The next item may be accepted while a result still waits in the
// output register. Configuration writes are taken in any cycle (cfg_ready is
// always high) and should be made only while the block is idle.
module pid_deadband_clamp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pdc_pkg::in_t        in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pdc_pkg::out_t            out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire pdc_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]         cfg_data
);

	pdc_pkg::cmd_t  cmd;
	pdc_pkg::stat_t stat;

	pdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

FILE: rtl/core/pdc_div.sv
`default_nettype none
module pdc_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [pdc_pkg::DIV_WIDTH-1:0]  dividend,
	input  wire logic [15:0]                    divisor,
	output logic                                done,
	output logic [pdc_pkg::DIV_WIDTH-1:0]       quotient
);

	localparam logic [pdc_pkg::DIV_CNT_WIDTH-1:0] LAST_CNT =
		pdc_pkg::DIV_CNT_WIDTH'(pdc_pkg::DIV_STEPS - 1);

	logic                               busy_q;
	logic [pdc_pkg::DIV_CNT_WIDTH-1:0]  cnt_q;
	logic [15:0]                        rem_q;
	logic [pdc_pkg::DIV_WIDTH-1:0]      quo_q;
	logic [15:0]                        rem_nx;
	logic [pdc_pkg::DIV_WIDTH-1:0]      quo_nx;

	// restoring division, a few quotient bits per cycle
	always_comb begin
		logic [16:0] r;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < pdc_pkg::DIV_BITS; i++) begin
			r = {rem_nx, quo_nx[pdc_pkg::DIV_WIDTH-1]};
			quo_nx = {quo_nx[pdc_pkg::DIV_WIDTH-2:0], 1'b0};
			if (r >= {1'b0, divisor}) begin
				r = r - {1'b0, divisor};
				quo_nx[0] = 1'b1;
			end
			rem_nx = r[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_CNT) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign done     = busy_q && (cnt_q == LAST_CNT);
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/pdc_dp.sv
`default_nettype none
module pdc_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pdc_pkg::cmd_t       cmd,
	output pdc_pkg::stat_t           stat,
	input  wire pdc_pkg::in_t        in_data,
	output pdc_pkg::out_t            out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire pdc_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]         cfg_data
);

	logic signed [15:0] kp_q, ki_q, kd_q;
	logic [14:0]        out_lim_q, deadband_q;

	logic signed [31:0] integral_q;
	logic signed [15:0] last_error_q;

	logic signed [15:0] e_q;
	logic [15:0]        dt_q;
	logic signed [16:0] diff_q;
	logic signed [31:0] p_q;
	logic signed [31:0] kie_q;
	logic signed [32:0] kdd_q;
	logic signed [47:0] prod_q;
	logic               neg_q;
	logic signed [50:0] sum_q;
	pdc_pkg::out_t      out_q;

	logic signed [32:0] isum_w;
	logic signed [32:0] kdd_mag;
	logic [pdc_pkg::DIV_WIDTH-1:0] div_dividend;
	logic [pdc_pkg::DIV_WIDTH-1:0] quo;
	logic signed [48:0] d_w;
	logic signed [42:0] q_w;
	logic signed [42:0] lim_pos, lim_neg;
	logic [16:0]        mag_w;
	logic               div_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			out_lim_q  <= '1;
			deadband_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pdc_pkg::REG_KP:       kp_q       <= cfg_data;
				pdc_pkg::REG_KI:       ki_q       <= cfg_data;
				pdc_pkg::REG_KD:       kd_q       <= cfg_data;
				pdc_pkg::REG_OUT_LIM:  out_lim_q  <= cfg_data[14:0];
				pdc_pkg::REG_DEADBAND: deadband_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign isum_w = $signed({integral_q[31], integral_q}) + $signed({prod_q[47], prod_q[47:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			last_error_q <= '0;
		end else begin
			if (cmd.load) begin
				last_error_q <= in_data.error_in;
			end
			if (cmd.acc) begin
				if (isum_w[32] != isum_w[31]) begin
					integral_q <= isum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				end else begin
					integral_q <= isum_w[31:0];
				end
			end
		end
	end

	assign kdd_mag      = kdd_q[32] ? -kdd_q : kdd_q;
	assign div_dividend = {kdd_mag[31:0], 16'h0000};

	pdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.acc),
		.dividend (div_dividend),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign stat.div_done = div_done;

	// zero time step gives no derivative term
	always_comb begin
		if (dt_q == '0) begin
			d_w = '0;
		end else if (neg_q) begin
			d_w = -$signed({1'b0, quo});
		end else begin
			d_w = $signed({1'b0, quo});
		end
	end

	assign q_w     = sum_q[50:8];
	assign lim_pos = $signed({28'd0, out_lim_q});
	assign lim_neg = -lim_pos;
	assign mag_w   = e_q[15] ? (17'd0 - {e_q[15], e_q}) : {1'b0, e_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q    <= in_data.error_in;
			dt_q   <= in_data.time_step;
			diff_q <= $signed({in_data.error_in[15], in_data.error_in})
				- $signed({last_error_q[15], last_error_q});
		end
		if (cmd.mul1) begin
			p_q   <= kp_q * e_q;
			kie_q <= ki_q * e_q;
			kdd_q <= kd_q * diff_q;
		end
		if (cmd.mul2) begin
			prod_q <= kie_q * $signed({1'b0, dt_q});
		end
		if (cmd.acc) begin
			neg_q <= kdd_q[32];
		end
		if (cmd.sum) begin
			sum_q <= 51'(p_q) + 51'(integral_q) + 51'(d_w);
		end
		if (cmd.out_load) begin
			if (mag_w <= {2'b00, deadband_q}) begin
				out_q.drive       <= '0;
				out_q.in_deadband <= 1'b1;
				out_q.limited     <= 1'b0;
			end else if (q_w > lim_pos) begin
				out_q.drive       <= {1'b0, out_lim_q};
				out_q.in_deadband <= 1'b0;
				out_q.limited     <= 1'b1;
			end else if (q_w < lim_neg) begin
				out_q.drive       <= lim_neg[15:0];
				out_q.in_deadband <= 1'b0;
				out_q.limited     <= 1'b1;
			end else begin
				out_q.drive       <= q_w[15:0];
				out_q.in_deadband <= 1'b0;
				out_q.limited     <= 1'b0;
			end
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/pdc_ctrl.sv
`default_nettype none
module pdc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output pdc_pkg::cmd_t       cmd,
	input  wire pdc_pkg::stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_ACC,
		S_DIV,
		S_SUM,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mul1     = (state_q == S_MUL1);
		cmd.mul2     = (state_q == S_MUL2);
		cmd.acc      = (state_q == S_ACC);
		cmd.sum      = (state_q == S_SUM);
		cmd.out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (out_valid_q && out_ready && !cmd.out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_ACC;
				S_ACC:  state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM:  state_q <= S_OUT;
				S_OUT: begin
					// wait until the previous item has left the output register
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_div_to_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && stat.div_done |=> (state_q == S_SUM))
		else $error("divide state did not advance on divider done");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && (state_q == S_IDLE))
		else $error("result load did not raise out_valid");

	a_mul1_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |-> $past(in_valid && in_ready))
		else $error("multiply stage entered without an accepted item");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTINGS_PER_MODE = 5;
	localparam int ITEMS_PER_SETTING = 95;
	localparam int PRESSURE_ITEMS = 30;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS = 50;
	localparam longint ACC_TOP = 64'sd2147483647;
	localparam longint ACC_BOT = -64'sd2147483648;
	// indexes past the last register, writes there must change nothing
	localparam pdc_pkg::cfg_index_t REG_SPARE_LO = 3'd5;
	localparam pdc_pkg::cfg_index_t REG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		pdc_pkg::cfg_index_t idx;
		logic [15:0]         val;
		pdc_pkg::in_t        item;
		logic                known;
		pdc_pkg::out_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pdc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pdc_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	pdc_pkg::cfg_index_t cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// controller copy: gains, limits and the two state registers
	longint m_kp, m_ki, m_kd, m_lim, m_db;
	longint integ, prev_err;

	pdc_pkg::out_t pending_drive [$];
	row_t dir_rows [$];

	int err_count = 0;
	int n_items = 0;
	int n_results = 0;
	int n_clamped = 0;
	int n_dead = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	pid_deadband_clamp u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				pending_drive.size());
			$display("** pid_deadband_clamp: FAILED **");
			$finish;
		end
	end

	function automatic void reset_controller();
		m_kp = 0;
		m_ki = 0;
		m_kd = 0;
		m_lim = 32767;
		m_db = 0;
		integ = 0;
		prev_err = 0;
	endfunction

	function automatic void apply_reg(pdc_pkg::cfg_index_t idx, logic [15:0] val);
		case (idx)
			pdc_pkg::REG_KP: m_kp = longint'($signed(val));
			pdc_pkg::REG_KI: m_ki = longint'($signed(val));
			pdc_pkg::REG_KD: m_kd = longint'($signed(val));
			pdc_pkg::REG_OUT_LIM: m_lim = longint'(val[14:0]);
			pdc_pkg::REG_DEADBAND: m_db = longint'(val[14:0]);
			default: ;
		endcase
	endfunction

	function automatic pdc_pkg::out_t pid_step(pdc_pkg::in_t it);
		longint e, dt, prop, isum, deriv, q, mag;
		pdc_pkg::out_t r;
		e = longint'($signed(it.error_in));
		dt = longint'(it.time_step);
		prop = m_kp * e;
		// integral increment floors to Q24.8, then the sum saturates
		isum = integ + ((m_ki * e * dt) >>> 16);
		if (isum > ACC_TOP)
			isum = ACC_TOP;
		if (isum < ACC_BOT)
			isum = ACC_BOT;
		integ = isum;
		if (dt != 0)
			deriv = (m_kd * (e - prev_err) * 65536) / dt;
		else
			deriv = 0;
		prev_err = e;
		q = (prop + isum + deriv) >>> 8;
		mag = (e < 0) ? -e : e;
		r = '0;
		if (mag <= m_db) begin
			r.in_deadband = 1'b1;
		end else if (q > m_lim) begin
			r.drive = 16'(m_lim);
			r.limited = 1'b1;
		end else if (q < -m_lim) begin
			r.drive = 16'(-m_lim);
			r.limited = 1'b1;
		end else begin
			r.drive = 16'(q);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got_v, longint want_v);
		err_count++;
		// keep the log short when everything goes wrong
		if (err_count <= MAX_PRINTS)
			$display("mismatch at result %0d: %s got %0d expected %0d", n_results, what,
				got_v, want_v);
	endtask

	always @(posedge clk) begin
		pdc_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (out_data.limited)
				n_clamped++;
			if (out_data.in_deadband)
				n_dead++;
			if (pending_drive.size() == 0) begin
				report_mismatch("unexpected result, drive", $signed(out_data.drive), 0);
			end else begin
				want = pending_drive.pop_front();
				if (out_data.drive !== want.drive)
					report_mismatch("drive", $signed(out_data.drive), $signed(want.drive));
				if (out_data.in_deadband !== want.in_deadband)
					report_mismatch("in_deadband", out_data.in_deadband, want.in_deadband);
				if (out_data.limited !== want.limited)
					report_mismatch("limited", out_data.limited, want.limited);
			end
		end
	end

	// receiver: random stalls, or a long hold when the driver asks for one
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(pdc_pkg::in_t it, logic known, pdc_pkg::out_t want);
		pdc_pkg::out_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = pid_step(it);
		pending_drive.push_back(known ? want : predicted);
		n_items++;
	endtask

	task automatic drain_items();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_drive.size() != 0);
	endtask

	task automatic write_reg(pdc_pkg::cfg_index_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_cfg(pdc_pkg::cfg_index_t idx, logic [15:0] val);
		dir_rows.push_back('{kind: ROW_CFG, idx: idx, val: val, item: '0, known: 1'b0,
			want: '0});
	endfunction

	function automatic void add_item(int e, int dt);
		dir_rows.push_back('{kind: ROW_ITEM, idx: '0, val: '0,
			item: '{error_in: 16'(e), time_step: 16'(dt)}, known: 1'b0, want: '0});
	endfunction

	function automatic void add_known(int e, int dt, int drive, logic dead, logic lim);
		dir_rows.push_back('{kind: ROW_ITEM, idx: '0, val: '0,
			item: '{error_in: 16'(e), time_step: 16'(dt)}, known: 1'b1,
			want: '{drive: 16'(drive), in_deadband: dead, limited: lim}});
	endfunction

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			1: return 16'($urandom_range(0, 1024)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [14:0] rand_mag();
		case ($urandom_range(4))
			0: return 15'h7FFF;
			1: return 15'h0;
			2: return 15'($urandom);
			default: return 15'($urandom_range(0, 2048));
		endcase
	endfunction

	function automatic pdc_pkg::in_t rand_item();
		pdc_pkg::in_t it;
		int mag;
		case ($urandom_range(9))
			0: it.error_in = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1, 2: begin
				// straddle the deadband edge
				mag = int'(m_db) + $urandom_range(0, 4) - 2;
				it.error_in = $urandom_range(1) ? 16'(mag) : 16'(-mag);
			end
			default: it.error_in = 16'($urandom);
		endcase
		case ($urandom_range(5))
			0, 1: it.time_step = 16'($urandom_range(1, 16));
			2: it.time_step = 16'hFFFF;
			default: it.time_step = 16'($urandom_range(1, 65535));
		endcase
		return it;
	endfunction

	task automatic new_settings();
		drain_items();
		write_reg(pdc_pkg::REG_KP, rand_gain());
		write_reg(pdc_pkg::REG_KI, rand_gain());
		write_reg(pdc_pkg::REG_KD, rand_gain());
		write_reg(pdc_pkg::REG_OUT_LIM, {1'($urandom_range(1)), rand_mag()});
		write_reg(pdc_pkg::REG_DEADBAND, {1'($urandom_range(1)),
			($urandom_range(7) == 0) ? rand_mag() : 15'($urandom_range(0, 256))});
		if ($urandom_range(3) == 0)
			write_reg(pdc_pkg::cfg_index_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				16'($urandom));
	endtask

	initial begin
		int mode;
		int n_directed;
		reset_controller();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gains zero after reset, so the drive is zero; zero error sits in a zero deadband
		add_known(0, 1, 0, 1'b1, 1'b0);
		add_known(32767, 65535, 0, 1'b0, 1'b0);
		add_known(-32768, 1, 0, 1'b0, 1'b0);
		add_cfg(pdc_pkg::REG_KP, 16'h7FFF);
		add_cfg(pdc_pkg::REG_OUT_LIM, 16'd100);
		add_known(32767, 1, 100, 1'b0, 1'b1);
		add_known(-32768, 1, -100, 1'b0, 1'b1);
		// top bit of the write is dropped, leaving the widest deadband
		add_cfg(pdc_pkg::REG_DEADBAND, 16'hFFFF);
		add_known(32767, 1, 0, 1'b1, 1'b0);
		add_known(-32768, 1, -100, 1'b0, 1'b1);
		add_cfg(pdc_pkg::REG_DEADBAND, 16'h0000);
		add_cfg(pdc_pkg::REG_OUT_LIM, 16'hFFFF);
		add_cfg(pdc_pkg::REG_KP, 16'h8000);
		add_cfg(pdc_pkg::REG_KI, 16'h7FFF);
		add_cfg(pdc_pkg::REG_KD, 16'h7FFF);
		add_item(32767, 65535);
		add_item(32767, 65535);
		add_item(-32768, 65535);
		add_item(32767, 65535);
		// zero time step: no derivative and no integral change
		add_item(1, 0);
		add_item(-1, 0);
		add_cfg(REG_SPARE_LO, 16'h1234);
		add_cfg(REG_SPARE_HI, 16'hFFFF);
		add_cfg(pdc_pkg::REG_KD, 16'h8000);
		add_cfg(pdc_pkg::REG_KI, 16'h8000);
		add_item(32767, 65535);
		add_item(32767, 65535);
		add_item(32767, 65535);
		add_item(-32768, 1);
		add_item(0, 65535);
		add_cfg(pdc_pkg::REG_KP, 16'h0000);
		add_cfg(pdc_pkg::REG_KI, 16'h0000);
		add_cfg(pdc_pkg::REG_KD, 16'h0000);
		add_cfg(pdc_pkg::REG_OUT_LIM, 16'h0000);
		add_item(5, 7);
		add_item(-1, 3);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_items();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
			end
		end
		n_directed = n_items;

		// idling modes: none, sender idle, receiver stalling, both
		for (mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 87; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 87; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			repeat (SETTINGS_PER_MODE) begin
				new_settings();
				repeat (ITEMS_PER_SETTING)
					send_item(rand_item(), 1'b0, '0);
			end
		end

		// hold the output side off while items keep coming, so the input stalls
		new_settings();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		repeat (PRESSURE_ITEMS)
			send_item(rand_item(), 1'b0, '0);

		drain_items();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent (%0d directed), %0d results seen: %0d clamped, %0d in deadband",
			n_items, n_directed, n_results, n_clamped, n_dead);
		$display("random gains and limits under four idling mixes, then a %0d-cycle output hold",
			HOLD_CYCLES);
		if (err_count == 0) begin
			$display("** pid_deadband_clamp: PASSED **");
		end else begin
			$display("%0d mismatches", err_count);
			$display("** pid_deadband_clamp: FAILED **");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/pdc_pkg.sv
rtl/core/pdc_div.sv
rtl/core/pdc_dp.sv
rtl/core/pdc_ctrl.sv
rtl/core/pid_deadband_clamp.sv
bench/tb_top.sv
